>>> rtl/atpr_pkg.sv
// shared types and constants for the audio timer and port register page
package atpr_pkg;

    localparam int SLOW_PERIOD = 128;
    localparam int FAST_PERIOD = 16;

    localparam int TIMER_COUNT = 3;
    localparam int FAST_TIMER  = 2;
    localparam int IN_PORTS    = 6;
    localparam int OUT_PORTS   = 4;

    localparam logic [6:0] SLOW_RELOAD = 7'(SLOW_PERIOD - 1);
    localparam logic [6:0] FAST_RELOAD = 7'(FAST_PERIOD - 1);

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_CPU_READ   = 3'd1,
        OP_CPU_WRITE  = 3'd2,
        OP_HOST_WRITE = 3'd3,
        OP_HOST_READ  = 3'd4
    } t_opcode;

    localparam logic [3:0] REG_CONTROL  = 4'h1;
    localparam logic [3:0] REG_DSP_ADDR = 4'h2;
    localparam logic [3:0] REG_PORT0    = 4'h4;
    localparam logic [3:0] REG_PORT3    = 4'h7;
    localparam logic [3:0] REG_PORT4    = 4'h8;
    localparam logic [3:0] REG_PORT5    = 4'h9;
    localparam logic [3:0] REG_TARGET0  = 4'hA;
    localparam logic [3:0] REG_TARGET2  = 4'hC;
    localparam logic [3:0] REG_COUNT0   = 4'hD;
    localparam logic [3:0] REG_COUNT2   = 4'hF;

    localparam int CTRL_CLR_PORTS01 = 4;
    localparam int CTRL_CLR_PORTS23 = 5;
    localparam int CTRL_ROM_VISIBLE = 7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] register_offset;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       rom_visible;
    } t_out_item;

    typedef struct packed {
        logic       tick;
        logic       ctrl_wr;
        logic       enable;
        logic       target_wr;
        logic       read_clr;
        logic [7:0] data;
    } t_tmr_ctrl;

endpackage

>>> rtl/atpr_timer.sv
// one timer: prescaler, 8-bit divider with target and 4-bit output counter
module atpr_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atpr_pkg::t_tmr_ctrl i_ctrl,
    input  logic [6:0]          i_reload,
    output logic [3:0]          o_count
);
    import atpr_pkg::*;

    logic [6:0] r_prescale, n_prescale;
    logic [7:0] r_divider, n_divider;
    logic [7:0] r_target, n_target;
    logic [3:0] r_count, n_count;
    logic       r_enable, n_enable;
    logic [7:0] div_inc;

    assign div_inc = r_divider + 8'd1;

    always_comb begin
        n_prescale = r_prescale;
        n_divider  = r_divider;
        n_target   = r_target;
        n_count    = r_count;
        n_enable   = r_enable;
        if (i_ctrl.tick) begin
            if (r_prescale == 7'd0) begin
                n_prescale = i_reload;
                if (r_enable) begin
                    if (div_inc == r_target) begin
                        n_divider = 8'd0;
                        n_count   = r_count + 4'd1;
                    end else begin
                        n_divider = div_inc;
                    end
                end
            end else begin
                n_prescale = r_prescale - 7'd1;
            end
        end
        if (i_ctrl.ctrl_wr) begin
            // starting a stopped timer restarts divider and counter
            if (!r_enable && i_ctrl.enable) begin
                n_divider = 8'd0;
                n_count   = 4'd0;
            end
            n_enable = i_ctrl.enable;
        end
        if (i_ctrl.target_wr) begin
            n_target = i_ctrl.data;
        end
        if (i_ctrl.read_clr) begin
            n_count = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_divider  <= '0;
            r_target   <= '0;
            r_count    <= '0;
            r_enable   <= 1'b0;
        end else begin
            r_prescale <= n_prescale;
            r_divider  <= n_divider;
            r_target   <= n_target;
            r_count    <= n_count;
            r_enable   <= n_enable;
        end
    end

    assign o_count = r_count;

endmodule

>>> rtl/audio_timer_port_registers_top.sv
// I/O register page of an audio coprocessor: three timers, mailbox ports, control, DSP address.
// Each transaction is a tick, a CPU read or write of offsets F0-FF, or a host mailbox access.
// A transaction is registered on entry and handled from that input register, all three timers
// in parallel, so the block takes one transaction per clock while the output is not stalled
// and returns exactly one result per transaction, held in the result register, which lets a new
// transaction enter while a finished one waits. No clearing pass after reset is needed.
module audio_timer_port_registers_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  atpr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output atpr_pkg::t_out_item o_out_item
);
    import atpr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic [7:0] r_in_ports [IN_PORTS];
    logic [7:0] r_out_ports [OUT_PORTS];
    logic [7:0] r_dsp_addr;
    logic       r_rom_visible, n_rom_visible;

    logic       in_accept;
    logic       advance;
    logic       is_tick, is_cpu_rd, is_cpu_wr, is_host_wr, is_host_rd;
    logic       host_ok;
    logic [3:0] off;
    logic [7:0] wdata;
    logic [2:0] in_idx;
    logic [1:0] out_idx;
    logic [7:0] rd_data;

    t_tmr_ctrl  tmr_ctrl [TIMER_COUNT];
    logic [3:0] tmr_count [TIMER_COUNT];

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign off     = r_in_item.register_offset;
    assign wdata   = r_in_item.write_data;
    assign in_idx  = 3'(off - REG_PORT0);
    assign out_idx = off[1:0];
    assign host_ok = (off[3:2] == 2'b00);

    assign is_tick    = advance && (r_in_item.opcode == OP_TICK);
    assign is_cpu_rd  = advance && (r_in_item.opcode == OP_CPU_READ);
    assign is_cpu_wr  = advance && (r_in_item.opcode == OP_CPU_WRITE);
    assign is_host_wr = advance && (r_in_item.opcode == OP_HOST_WRITE) && host_ok;
    assign is_host_rd = advance && (r_in_item.opcode == OP_HOST_READ) && host_ok;

    // timers
    for (genvar t = 0; t < TIMER_COUNT; t++) begin : g_timer
        always_comb begin
            tmr_ctrl[t].tick      = is_tick;
            tmr_ctrl[t].ctrl_wr   = is_cpu_wr && (off == REG_CONTROL);
            tmr_ctrl[t].enable    = wdata[t];
            tmr_ctrl[t].target_wr = is_cpu_wr && (off == REG_TARGET0 + 4'(t));
            tmr_ctrl[t].read_clr  = is_cpu_rd && (off == REG_COUNT0 + 4'(t));
            tmr_ctrl[t].data      = wdata;
        end

        atpr_timer u_timer (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (tmr_ctrl[t]),
            .i_reload ((t == FAST_TIMER) ? FAST_RELOAD : SLOW_RELOAD),
            .o_count  (tmr_count[t])
        );
    end

    // read data
    always_comb begin
        rd_data = 8'd0;
        if (is_cpu_rd) begin
            case (off) inside
                REG_DSP_ADDR:             rd_data = r_dsp_addr;
                [REG_PORT0:REG_PORT5]:    rd_data = r_in_ports[in_idx];
                [REG_COUNT0:REG_COUNT2]: begin
                    case (off)
                        REG_COUNT0:         rd_data = {4'd0, tmr_count[0]};
                        REG_COUNT0 + 4'd1:  rd_data = {4'd0, tmr_count[1]};
                        default:            rd_data = {4'd0, tmr_count[2]};
                    endcase
                end
                default:                  rd_data = 8'd0;
            endcase
        end else if (is_host_rd) begin
            rd_data = r_out_ports[out_idx];
        end
    end

    always_comb begin
        n_rom_visible = r_rom_visible;
        if (is_cpu_wr && (off == REG_CONTROL)) begin
            n_rom_visible = wdata[CTRL_ROM_VISIBLE];
        end
    end

    // port and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < IN_PORTS; i++) begin
                r_in_ports[i] <= 8'd0;
            end
            for (int i = 0; i < OUT_PORTS; i++) begin
                r_out_ports[i] <= 8'd0;
            end
            r_dsp_addr    <= 8'd0;
            r_rom_visible <= 1'b1;
        end else begin
            r_rom_visible <= n_rom_visible;
            if (is_cpu_wr) begin
                case (off) inside
                    REG_CONTROL: begin
                        if (wdata[CTRL_CLR_PORTS01]) begin
                            r_in_ports[0] <= 8'd0;
                            r_in_ports[1] <= 8'd0;
                        end
                        if (wdata[CTRL_CLR_PORTS23]) begin
                            r_in_ports[2] <= 8'd0;
                            r_in_ports[3] <= 8'd0;
                        end
                    end
                    REG_DSP_ADDR:          r_dsp_addr <= wdata;
                    [REG_PORT0:REG_PORT3]: r_out_ports[out_idx] <= wdata;
                    [REG_PORT4:REG_PORT5]: r_in_ports[in_idx] <= wdata;
                    default: begin
                    end
                endcase
            end
            if (is_host_wr) begin
                r_in_ports[{1'b0, out_idx}] <= wdata;
            end
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item.read_data   <= rd_data;
            r_out_item.rom_visible <= n_rom_visible;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/atpr_checker.sv
// port-level checks for the audio timer and port register page, bound to the top level
module atpr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input atpr_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input atpr_pkg::t_out_item o_out_item
);
    import atpr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("input transaction changed while stalled");

    // input side only stalls when output side does
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled without output stall");

    // reset leaves nothing pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pending transaction after reset");

    // accepted transaction with free output produces a result through the input and result registers
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

bind audio_timer_port_registers_top atpr_checker u_atpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
